// ===== src/rrpw_pkg.sv =====
`timescale 1ns / 1ps

package rrpw_pkg;

    // Field and register widths.
    localparam int COORD_IN_W  = 13;
    localparam int PANEL_W     = 11;
    localparam int COORD_W     = 16;
    localparam int WIN_W       = 10;
    localparam int BYTE_COL_W  = 7;
    localparam int BPR_W       = 8;
    localparam int CFG_IDX_W   = 2;

    // Default cap on either panel side.
    localparam int MAX_PANEL_SIDE_DEF = 1024;

    // Register reset values.
    localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = PANEL_W'(200);
    localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = PANEL_W'(200);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROTATION     = 2'd0,
        REG_PANEL_WIDTH  = 2'd1,
        REG_PANEL_HEIGHT = 2'd2
    } cfg_index_t;

    // Quarter turns from logical to physical.
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    // Logical edges of the rectangle, inclusive.
    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] y1;
        logic                      bad;
    } edges_t;

    // Physical bounding box, before or after clipping.
    typedef struct packed {
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] ye;
        logic                      empty;
    } box_t;

endpackage

// ===== src/rotated_rect_to_panel_window.sv =====
`timescale 1ns / 1ps

// Rotated rectangle to panel update window.
// The input channel (s_valid/s_ready) carries one logical rectangle per word:
// its left and top corner and its width and height, all two's complement.
// The result channel (m_valid/m_ready) carries one window word per rectangle:
// an empty flag, the byte-aligned column range, the row range, the byte
// columns and the bytes per row. When the flag is set every other field is 0.
// The block is a four-stage pipeline: edges, rotation, clipping, alignment.
// m_valid rises once an accepted rectangle has been registered in turn by the
// edge, rotation, clipping and output registers. One rectangle can
// be accepted every cycle, limited only by the receiver.
// When the receiver holds m_ready low the stages fill up behind the output
// register; empty stages still take new words, and nothing is dropped or
// repeated. Configuration (rotation, panel width, panel height) is written
// through cfg_wr_en/cfg_index/cfg_data and must only change while the
// pipeline is empty. Reset empties the pipeline and loads rotation 0 and a
// 200 by 200 panel.
module rotated_rect_to_panel_window #(
    parameter int MAX_PANEL_SIDE = rrpw_pkg::MAX_PANEL_SIDE_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,

    input  logic                                        cfg_wr_en,
    input  logic [rrpw_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [rrpw_pkg::PANEL_W-1:0]                cfg_data,

    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic signed [rrpw_pkg::COORD_IN_W-1:0]      s_rect_x,
    input  logic signed [rrpw_pkg::COORD_IN_W-1:0]      s_rect_y,
    input  logic signed [rrpw_pkg::COORD_IN_W-1:0]      s_rect_width,
    input  logic signed [rrpw_pkg::COORD_IN_W-1:0]      s_rect_height,

    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic                                        m_empty_res,
    output logic [rrpw_pkg::WIN_W-1:0]                  m_window_x_start,
    output logic [rrpw_pkg::WIN_W-1:0]                  m_window_x_end,
    output logic [rrpw_pkg::WIN_W-1:0]                  m_window_y_start,
    output logic [rrpw_pkg::WIN_W-1:0]                  m_window_y_end,
    output logic [rrpw_pkg::BYTE_COL_W-1:0]             m_byte_col_start,
    output logic [rrpw_pkg::BYTE_COL_W-1:0]             m_byte_col_end,
    output logic [rrpw_pkg::BPR_W-1:0]                  m_bytes_per_row
);

    import rrpw_pkg::*;

    // Width wide enough for both the panel registers and the cap.
    localparam int CAP_W = $clog2(MAX_PANEL_SIDE + 1);
    localparam int CMP_W = (CAP_W > PANEL_W) ? CAP_W : PANEL_W;
    localparam logic [CMP_W-1:0] MAX_SIDE = CMP_W'(MAX_PANEL_SIDE);

    // Configuration registers.
    rot_t               rotation_reg;
    logic [PANEL_W-1:0] panel_width_reg;
    logic [PANEL_W-1:0] panel_height_reg;

    // Effective panel size.
    logic [CMP_W-1:0]          pw_wide;
    logic [CMP_W-1:0]          ph_wide;
    logic [CMP_W-1:0]          pw_cap;
    logic [CMP_W-1:0]          ph_cap;
    logic signed [COORD_W-1:0] pw_s;
    logic signed [COORD_W-1:0] ph_s;
    logic signed [COORD_W-1:0] pw_m1;
    logic signed [COORD_W-1:0] ph_m1;

    // Pipeline stages.
    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    logic   rdy1, rdy2, rdy3, rdy4;
    edges_t s1_reg, s1_next;
    box_t   s2_reg, s2_next;
    box_t   s3_reg, s3_next;

    // Output register.
    logic                    empty_reg,     empty_next;
    logic [WIN_W-1:0]        x_start_reg,   x_start_next;
    logic [WIN_W-1:0]        x_end_reg,     x_end_next;
    logic [WIN_W-1:0]        y_start_reg,   y_start_next;
    logic [WIN_W-1:0]        y_end_reg,     y_end_next;
    logic [BYTE_COL_W-1:0]   bcol_start_reg, bcol_start_next;
    logic [BYTE_COL_W-1:0]   bcol_end_reg,  bcol_end_next;
    logic [BPR_W-1:0]        bpr_reg,       bpr_next;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg     <= ROT_0;
            panel_width_reg  <= PANEL_WIDTH_RST;
            panel_height_reg <= PANEL_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROTATION:     rotation_reg     <= rot_t'(cfg_data[1:0]);
                REG_PANEL_WIDTH:  panel_width_reg  <= cfg_data;
                REG_PANEL_HEIGHT: panel_height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Cap both sides and round the width down to whole bytes.
    always_comb begin
        pw_wide = CMP_W'(panel_width_reg);
        ph_wide = CMP_W'(panel_height_reg);
        pw_cap  = (pw_wide > MAX_SIDE) ? MAX_SIDE : pw_wide;
        ph_cap  = (ph_wide > MAX_SIDE) ? MAX_SIDE : ph_wide;
        pw_s    = signed'(COORD_W'(pw_cap & ~CMP_W'(7)));
        ph_s    = signed'(COORD_W'(ph_cap));
        pw_m1   = pw_s - COORD_W'(1);
        ph_m1   = ph_s - COORD_W'(1);
    end

    // Handshake: a stage takes a new word when it is empty or moves on.
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: inclusive logical edges and the degenerate cases.
    always_comb begin
        s1_next.x0  = COORD_W'(s_rect_x);
        s1_next.y0  = COORD_W'(s_rect_y);
        s1_next.x1  = COORD_W'(s_rect_x) + COORD_W'(s_rect_width) - COORD_W'(1);
        s1_next.y1  = COORD_W'(s_rect_y) + COORD_W'(s_rect_height) - COORD_W'(1);
        s1_next.bad = (s_rect_width <= 0) || (s_rect_height <= 0)
                      || (pw_s == '0) || (ph_s == '0);
    end

    // Stage 2: rotate. Each turn maps the edge ranges onto the bounding box.
    always_comb begin
        s2_next.empty = s1_reg.bad;
        unique case (rotation_reg)
            ROT_0: begin
                s2_next.xs = s1_reg.x0;
                s2_next.xe = s1_reg.x1;
                s2_next.ys = s1_reg.y0;
                s2_next.ye = s1_reg.y1;
            end
            ROT_90: begin
                s2_next.xs = s1_reg.y0;
                s2_next.xe = s1_reg.y1;
                s2_next.ys = ph_m1 - s1_reg.x1;
                s2_next.ye = ph_m1 - s1_reg.x0;
            end
            ROT_180: begin
                s2_next.xs = pw_m1 - s1_reg.x1;
                s2_next.xe = pw_m1 - s1_reg.x0;
                s2_next.ys = ph_m1 - s1_reg.y1;
                s2_next.ye = ph_m1 - s1_reg.y0;
            end
            ROT_270: begin
                s2_next.xs = pw_m1 - s1_reg.y1;
                s2_next.xe = pw_m1 - s1_reg.y0;
                s2_next.ys = s1_reg.x0;
                s2_next.ye = s1_reg.x1;
            end
            default: begin
                s2_next.xs = s1_reg.x0;
                s2_next.xe = s1_reg.x1;
                s2_next.ys = s1_reg.y0;
                s2_next.ye = s1_reg.y1;
            end
        endcase
    end

    // Stage 3: clip to the panel and detect a box wholly off it.
    always_comb begin
        s3_next.xs    = (s2_reg.xs < 0) ? '0 : s2_reg.xs;
        s3_next.ys    = (s2_reg.ys < 0) ? '0 : s2_reg.ys;
        s3_next.xe    = (s2_reg.xe > pw_m1) ? pw_m1 : s2_reg.xe;
        s3_next.ye    = (s2_reg.ye > ph_m1) ? ph_m1 : s2_reg.ye;
        s3_next.empty = s2_reg.empty || (s3_next.xs > s3_next.xe)
                        || (s3_next.ys > s3_next.ye);
    end

    // Stage 4: widen the columns to whole bytes and form the outputs.
    always_comb begin
        logic signed [COORD_W-1:0] xs_al;
        logic signed [COORD_W-1:0] xe_or;
        logic signed [COORD_W-1:0] xe_al;
        logic signed [COORD_W-1:0] bs;
        logic signed [COORD_W-1:0] be;
        logic signed [COORD_W-1:0] cnt;
        xs_al = s3_reg.xs & ~COORD_W'(7);
        xe_or = s3_reg.xe | COORD_W'(7);
        xe_al = (xe_or > pw_m1) ? pw_m1 : xe_or;
        bs    = xs_al >>> 3;
        be    = xe_al >>> 3;
        cnt   = be - bs + COORD_W'(1);
        if (s3_reg.empty) begin
            empty_next      = 1'b1;
            x_start_next    = '0;
            x_end_next      = '0;
            y_start_next    = '0;
            y_end_next      = '0;
            bcol_start_next = '0;
            bcol_end_next   = '0;
            bpr_next        = '0;
        end else begin
            empty_next      = 1'b0;
            x_start_next    = xs_al[WIN_W-1:0];
            x_end_next      = xe_al[WIN_W-1:0];
            y_start_next    = s3_reg.ys[WIN_W-1:0];
            y_end_next      = s3_reg.ye[WIN_W-1:0];
            bcol_start_next = bs[BYTE_COL_W-1:0];
            bcol_end_next   = be[BYTE_COL_W-1:0];
            bpr_next        = cnt[BPR_W-1:0];
        end
    end

    // Stage payload registers move with their valid bits.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
        if (rdy2) begin
            s2_reg <= s2_next;
        end
        if (rdy3) begin
            s3_reg <= s3_next;
        end
        if (rdy4) begin
            empty_reg      <= empty_next;
            x_start_reg    <= x_start_next;
            x_end_reg      <= x_end_next;
            y_start_reg    <= y_start_next;
            y_end_reg      <= y_end_next;
            bcol_start_reg <= bcol_start_next;
            bcol_end_reg   <= bcol_end_next;
            bpr_reg        <= bpr_next;
        end
    end

    // Result channel.
    assign m_valid          = v4_reg;
    assign m_empty_res      = empty_reg;
    assign m_window_x_start = x_start_reg;
    assign m_window_x_end   = x_end_reg;
    assign m_window_y_start = y_start_reg;
    assign m_window_y_end   = y_end_reg;
    assign m_byte_col_start = bcol_start_reg;
    assign m_byte_col_end   = bcol_end_reg;
    assign m_bytes_per_row  = bpr_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import rrpw_pkg::*;

    // One logical rectangle as the sender sees it.
    typedef struct packed {
        int x;
        int y;
        int w;
        int h;
    } rect_t;

    // One panel update window as the block reports it.
    typedef struct packed {
        logic                  empty_flag;
        logic [WIN_W-1:0]      x_start;
        logic [WIN_W-1:0]      x_end;
        logic [WIN_W-1:0]      y_start;
        logic [WIN_W-1:0]      y_end;
        logic [BYTE_COL_W-1:0] col_start;
        logic [BYTE_COL_W-1:0] col_end;
        logic [BPR_W-1:0]      row_bytes;
    } window_t;

    // Directed row: rectangle, whether the window is typed in, and that window.
    typedef struct {
        int x, y, w, h;
        bit known;
        bit e;
        int xs, xe, ys, ye, bcs, bce, bpr;
    } dir_row_t;

    // Panel setting and idling for one phase of the random part.
    typedef struct {
        rot_t rot;
        int   pw;
        int   ph;
        int   send_idle;
        int   recv_stall;
    } phase_t;

    localparam int RAND_ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES        = 8;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [PANEL_W-1:0]           cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [COORD_IN_W-1:0] s_rect_x;
    logic signed [COORD_IN_W-1:0] s_rect_y;
    logic signed [COORD_IN_W-1:0] s_rect_width;
    logic signed [COORD_IN_W-1:0] s_rect_height;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_empty_res;
    logic [WIN_W-1:0]             m_window_x_start;
    logic [WIN_W-1:0]             m_window_x_end;
    logic [WIN_W-1:0]             m_window_y_start;
    logic [WIN_W-1:0]             m_window_y_end;
    logic [BYTE_COL_W-1:0]        m_byte_col_start;
    logic [BYTE_COL_W-1:0]        m_byte_col_end;
    logic [BPR_W-1:0]             m_bytes_per_row;

    // Local copy of the panel registers.
    rot_t               cur_rot;
    logic [PANEL_W-1:0] cur_pw;
    logic [PANEL_W-1:0] cur_ph;

    window_t pending_windows[$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    // Directed rectangles at the reset setting: rotation 0 on a 200 by 200 panel.
    dir_row_t directed_rows [19] = '{
        '{    0,     0,   200,   200, 1, 0,   0, 199,   0, 199,  0, 24, 25},
        '{    0,     0,     0,     5, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{    0,     0,     5, -4096, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{   -1,    -1,    -1,    -1, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{-4096, -4096,  4095,  4095, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{ 4095,  4095,  4095,  4095, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{ -100,  -100,  4095,  4095, 1, 0,   0, 199,   0, 199,  0, 24, 25},
        '{    3,     5,     2,     1, 1, 0,   0,   7,   5,   5,  0,  0,  1},
        '{  195,   199,     1,     1, 1, 0, 192, 199, 199, 199, 24, 24,  1},
        '{  200,     0,     1,     1, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{    0,   200,     1,     1, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{   -1,    -1,     1,     1, 1, 1,   0,   0,   0,   0,  0,  0,  0},
        '{   -1,    -1,     2,     2, 1, 0,   0,   7,   0,   0,  0,  0,  1},
        '{    9,    10,    17,     3, 0, 0,   0,   0,   0,   0,  0,  0,  0},
        '{ 2730, -2731, -2731,  2730, 0, 0,   0,   0,   0,   0,  0,  0,  0},
        '{-2731,  2730,  2730, -2731, 0, 0,   0,   0,   0,   0,  0,  0,  0},
        '{  100,    50,     1,  4095, 0, 0,   0,   0,   0,   0,  0,  0,  0},
        '{-3000,   199,  3200,     1, 0, 0,   0,   0,   0,   0,  0,  0,  0},
        '{  196,     0,     4,     1, 0, 0,   0,   0,   0,   0,  0,  0,  0}
    };

    // Panel settings, from the smallest to oversized and odd widths.
    phase_t phases [12] = '{
        '{ROT_90,  1024, 1024,  0,  0},
        '{ROT_180,    8,    1, 74,  0},
        '{ROT_270, 2047, 2047,  0, 74},
        '{ROT_0,     13,  300, 11, 11},
        '{ROT_90,   640,  480, 74,  0},
        '{ROT_180,    5,  100,  0,  0},
        '{ROT_270,   96,    0, 11, 11},
        '{ROT_0,   1024,    1,  0, 74},
        '{ROT_90,     8, 1024, 11, 11},
        '{ROT_180, 1031,  777,  0, 74},
        '{ROT_270,  250,  122, 74,  0},
        '{ROT_0,    200,  200,  0,  0}
    };

    rotated_rect_to_panel_window i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rect_x         (s_rect_x),
        .s_rect_y         (s_rect_y),
        .s_rect_width     (s_rect_width),
        .s_rect_height    (s_rect_height),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_empty_res      (m_empty_res),
        .m_window_x_start (m_window_x_start),
        .m_window_x_end   (m_window_x_end),
        .m_window_y_start (m_window_y_start),
        .m_window_y_end   (m_window_y_end),
        .m_byte_col_start (m_byte_col_start),
        .m_byte_col_end   (m_byte_col_end),
        .m_bytes_per_row  (m_bytes_per_row)
    );

    // Clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Window predicted from the rectangle and the current panel setting.
    function automatic window_t predict_window(rect_t r);
        int      pw, ph, xs, xe, ys, ye, xa, xb, px, py;
        int      cx [4];
        int      cy [4];
        window_t win;
        win = '0;
        win.empty_flag = 1'b1;
        pw = (int'(cur_pw) > MAX_PANEL_SIDE_DEF) ? MAX_PANEL_SIDE_DEF : int'(cur_pw);
        ph = (int'(cur_ph) > MAX_PANEL_SIDE_DEF) ? MAX_PANEL_SIDE_DEF : int'(cur_ph);
        pw = pw & ~7;
        if (r.w <= 0 || r.h <= 0 || pw <= 0 || ph <= 0)
            return win;
        cx = '{r.x, r.x + r.w - 1, r.x, r.x + r.w - 1};
        cy = '{r.y, r.y, r.y + r.h - 1, r.y + r.h - 1};
        xs = 0; xe = 0; ys = 0; ye = 0;
        // Rotate each corner and grow the bounding box.
        for (int i = 0; i < 4; i++) begin
            case (cur_rot)
                ROT_90: begin
                    px = cy[i];          py = ph - 1 - cx[i];
                end
                ROT_180: begin
                    px = pw - 1 - cx[i]; py = ph - 1 - cy[i];
                end
                ROT_270: begin
                    px = pw - 1 - cy[i]; py = cx[i];
                end
                default: begin
                    px = cx[i];          py = cy[i];
                end
            endcase
            if (i == 0 || px < xs) xs = px;
            if (i == 0 || px > xe) xe = px;
            if (i == 0 || py < ys) ys = py;
            if (i == 0 || py > ye) ye = py;
        end
        // Clip to the panel.
        if (xs < 0) xs = 0;
        if (ys < 0) ys = 0;
        if (xe > pw - 1) xe = pw - 1;
        if (ye > ph - 1) ye = ph - 1;
        if (xs > xe || ys > ye)
            return win;
        // Widen to whole bytes and clip the end again.
        xa = xs & ~7;
        xb = xe | 7;
        if (xb > pw - 1) xb = pw - 1;
        win.empty_flag = 1'b0;
        win.x_start    = xa[WIN_W-1:0];
        win.x_end      = xb[WIN_W-1:0];
        win.y_start    = ys[WIN_W-1:0];
        win.y_end      = ye[WIN_W-1:0];
        win.col_start  = xa[WIN_W-1:3];
        win.col_end    = xb[WIN_W-1:3];
        win.row_bytes  = BPR_W'((xb >> 3) - (xa >> 3) + 1);
        return win;
    endfunction

    function automatic int rand13();
        logic signed [COORD_IN_W-1:0] v;
        v = COORD_IN_W'($urandom);
        return int'(v);
    endfunction

    // Mostly rectangles on or near the panel; some hugging its edges; some noise.
    function automatic rect_t random_rect();
        rect_t r;
        int    lim, sel;
        lim = (cur_pw > cur_ph) ? int'(cur_pw) : int'(cur_ph);
        if (lim > MAX_PANEL_SIDE_DEF) lim = MAX_PANEL_SIDE_DEF;
        if (lim < 8) lim = 8;
        sel = $urandom_range(99);
        if (sel < 65) begin
            r.x = int'($urandom_range(lim + 32)) - 16;
            r.y = int'($urandom_range(lim + 32)) - 16;
            r.w = 1 + int'(($urandom_range(3) == 0) ? $urandom_range(lim) : $urandom_range(15));
            r.h = 1 + int'(($urandom_range(3) == 0) ? $urandom_range(lim) : $urandom_range(15));
        end else if (sel < 85) begin
            r.x = ($urandom_range(1) ? lim - 1 : 0) + int'($urandom_range(8)) - 4;
            r.y = ($urandom_range(1) ? lim - 1 : 0) + int'($urandom_range(8)) - 4;
            r.w = 1 + int'($urandom_range(9));
            r.h = 1 + int'($urandom_range(9));
        end else begin
            r.x = rand13();
            r.y = rand13();
            r.w = rand13();
            r.h = rand13();
        end
        return r;
    endfunction

    // Present one rectangle after random idle cycles and queue its window.
    task automatic send_rect(rect_t r, bit known, window_t typed_win);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_rect_x      <= COORD_IN_W'(r.x);
        s_rect_y      <= COORD_IN_W'(r.y);
        s_rect_width  <= COORD_IN_W'(r.w);
        s_rect_height <= COORD_IN_W'(r.h);
        do @(posedge aclk); while (!s_ready);
        pending_windows.push_back(known ? typed_win : predict_window(r));
    endtask

    // Stop sending and wait until every queued window has come back.
    task automatic drain_windows();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers on consecutive cycles.
    task automatic write_panel(rot_t rot, int pw, int ph);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ROTATION;
        cfg_data  <= PANEL_W'(rot);
        @(negedge aclk);
        cfg_index <= REG_PANEL_WIDTH;
        cfg_data  <= PANEL_W'(pw);
        @(negedge aclk);
        cfg_index <= REG_PANEL_HEIGHT;
        cfg_data  <= PANEL_W'(ph);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_rot = rot;
        cur_pw  = PANEL_W'(pw);
        cur_ph  = PANEL_W'(ph);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver stalls.
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare every accepted window word with the oldest prediction.
    always @(posedge aclk) begin
        window_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_windows.size() == 0) begin
                $display("%0t: window word with nothing expected", $time);
                mismatch_count++;
            end else begin
                want = pending_windows.pop_front();
                check_field("empty_res", want.empty_flag, m_empty_res);
                check_field("window_x_start", want.x_start, m_window_x_start);
                check_field("window_x_end", want.x_end, m_window_x_end);
                check_field("window_y_start", want.y_start, m_window_y_start);
                check_field("window_y_end", want.y_end, m_window_y_end);
                check_field("byte_col_start", want.col_start, m_byte_col_start);
                check_field("byte_col_end", want.col_end, m_byte_col_end);
                check_field("bytes_per_row", want.row_bytes, m_bytes_per_row);
            end
        end
    end

    // Stimulus.
    initial begin
        rect_t   r;
        window_t typed;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_ROTATION;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_rect_x      = '0;
        s_rect_y      = '0;
        s_rect_width  = '0;
        s_rect_height = '0;
        m_ready       = 1'b0;
        cur_rot       = ROT_0;
        cur_pw        = PANEL_WIDTH_RST;
        cur_ph        = PANEL_HEIGHT_RST;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rectangles at the reset setting.
        foreach (directed_rows[i]) begin
            r     = '{directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].w, directed_rows[i].h};
            typed = '{directed_rows[i].e,
                      WIN_W'(directed_rows[i].xs), WIN_W'(directed_rows[i].xe),
                      WIN_W'(directed_rows[i].ys), WIN_W'(directed_rows[i].ye),
                      BYTE_COL_W'(directed_rows[i].bcs), BYTE_COL_W'(directed_rows[i].bce),
                      BPR_W'(directed_rows[i].bpr)};
            send_rect(r, directed_rows[i].known, typed);
        end
        drain_windows();

        // Random rectangles, one panel setting per phase.
        foreach (phases[p]) begin
            write_panel(phases[p].rot, phases[p].pw, phases[p].ph);
            send_idle_pct  = phases[p].send_idle;
            recv_stall_pct = phases[p].recv_stall;
            for (int n = 0; n < RAND_ITEMS_PER_PHASE; n++) begin
                // Midway through one phase, hold off until the pipeline is empty.
                if (p == 2 && n == RAND_ITEMS_PER_PHASE / 2)
                    drain_windows();
                send_rect(random_rect(), 1'b0, '0);
            end
            drain_windows();
        end

        if (mismatch_count == 0)
            $display("rotated_rect_to_panel_window verification clean");
        else
            $display("rotated_rect_to_panel_window verification failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #3_200_000;
        $display("rotated_rect_to_panel_window verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rrpw_pkg.sv
src/rotated_rect_to_panel_window.sv
bench/testbench.sv
